FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the lookup unit RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacl assertion failed");

`endif

FILE: rtl/core/sacl_pkg.sv
// Shared types and constants of the set-associative cache tag lookup unit.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
package sacl_pkg;

    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 27;
    localparam int RANK_W      = 3;
    localparam int CNT_W       = 32;
    localparam int LFSR_W      = 16;
    localparam int WAY_MAX     = 8;
    localparam int WAY_IDX_W   = 3;
    localparam int ENTRY_IDX_W = 10;
    localparam int ROWS        = 128;
    localparam int ROW_IDX_W   = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // Replacement policy codes; the unused code behaves as random.
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    localparam logic [3:0] BLOCKS_LOG2_MIN   = 4'd4;
    localparam logic [3:0] BLOCKS_LOG2_MAX   = 4'd10;
    localparam logic [2:0] OFFSET_LOG2_MIN   = 3'd5;
    localparam logic [2:0] OFFSET_LOG2_MAX   = 3'd6;
    localparam logic [1:0] POLICY_RESET      = POL_FIFO;
    localparam logic [1:0] WAYS_LOG2_RESET   = 2'd0;
    localparam logic [3:0] BLOCKS_LOG2_RESET = 4'd4;
    localparam logic [2:0] OFFSET_LOG2_RESET = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY           = 2'd0,
        CFG_WAYS_LOG2        = 2'd1,
        CFG_BLOCKS_LOG2      = 2'd2,
        CFG_BLOCK_BYTES_LOG2 = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // One memory row holds eight consecutive entries; a set never spans rows.
    typedef entry_t [WAY_MAX-1:0] row_t;

    typedef struct packed {
        logic load;
        logic commit;
    } sacl_cmd_t;

    typedef struct packed {
        logic slot_free;
    } sacl_status_t;

endpackage

FILE: rtl/core/sacl_req_if.sv
// Request channel interface of the lookup unit: valid, ready and the address.
// Depends on sacl_pkg.
interface sacl_req_if import sacl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

FILE: rtl/core/sacl_rsp_if.sv
// Result channel interface of the lookup unit: valid, ready, hit and totals.
// Depends on sacl_pkg.
interface sacl_rsp_if import sacl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;

    modport source (output valid, output hit, output hit_total, output miss_total, input ready);
    modport sink (input valid, input hit, input hit_total, input miss_total, output ready);
endinterface

FILE: rtl/core/set_assoc_cache_tag_lookup_unit.sv
// The set row is read from the tag memory at the edge that accepts a request, and the
// result register loads when the lookup commits, which waits until that register is free.
// Only one request is in flight: a new request is not accepted until the previous one
// has committed its read-modify-write of the row; a stalled result holds the next commit.
// Reset: counters, LFSR and configuration take their reset values and per-row
// flags mark every row empty at once; there is no memory clearing pass.
`include "assert_macros.svh"

module set_assoc_cache_tag_lookup_unit import sacl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sacl_req_if.sink              req,
    sacl_rsp_if.source            rsp
);

    sacl_cmd_t    cmd;
    sacl_status_t status;
    logic         in_ready;
    logic         in_accept;

    sacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sacl_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .address    (req.address),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .hit        (rsp.hit),
        .hit_total  (rsp.hit_total),
        .miss_total (rsp.miss_total)
    );

    assign req.ready = in_ready;
    assign in_accept = req.valid && in_ready;

    `SACL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_accept, !req.ready)
    `SACL_ASSERT_IMPL(a_no_load_on_commit, clk, rst_n, cmd.commit, !cmd.load)
    `SACL_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, rsp.valid && req.ready)

endmodule

FILE: rtl/core/sacl_row_update.sv
// Compare and replacement logic for one set held in a memory row.
// Depends on sacl_pkg.
module sacl_row_update import sacl_pkg::*; (
    input  row_t                 row_cur,
    input  logic [TAG_W-1:0]     tag,
    input  logic [WAY_IDX_W-1:0] base,
    input  logic [1:0]           wl,
    input  logic [1:0]           policy,
    input  logic [WAY_IDX_W-1:0] pick,
    output row_t                 row_new,
    output logic                 hit,
    output logic                 lfsr_adv
);

    always_comb
    begin
        logic [WAY_IDX_W-1:0] ways_mask;
        logic [WAY_IDX_W-1:0] col;
        logic [WAY_IDX_W-1:0] hit_way;
        logic [WAY_IDX_W-1:0] free_way;
        logic [WAY_IDX_W-1:0] victim;
        logic [WAY_IDX_W-1:0] chosen;
        logic [WAY_IDX_W-1:0] target;
        logic [RANK_W-1:0]    top;
        logic [RANK_W-1:0]    best;
        logic [RANK_W-1:0]    r_chosen;
        logic [WAY_IDX_W:0]   nvalid;
        logic                 has_free;
        logic                 seen;
        logic                 do_promote;
        entry_t               e;

        ways_mask  = WAY_IDX_W'((4'd1 << wl) - 4'd1);
        col        = '0;
        hit_way    = '0;
        free_way   = '0;
        victim     = '0;
        chosen     = '0;
        target     = '0;
        top        = '0;
        best       = '0;
        r_chosen   = '0;
        nvalid     = '0;
        has_free   = 1'b0;
        seen       = 1'b0;
        do_promote = 1'b0;
        e          = '0;
        hit        = 1'b0;
        lfsr_adv   = 1'b0;

        // Sets are aligned to their size, so way w sits at column base | w.
        for (int w = 0; w < WAY_MAX; w++)
        begin
            if ((WAY_IDX_W'(w) & ~ways_mask) == '0)
            begin
                col = base | WAY_IDX_W'(w);
                e   = row_cur[col];
                if (e.valid)
                begin
                    nvalid = nvalid + 1'b1;
                    if (!hit && e.tag == tag)
                    begin
                        hit     = 1'b1;
                        hit_way = WAY_IDX_W'(w);
                    end
                end
                else if (!has_free)
                begin
                    has_free = 1'b1;
                    free_way = WAY_IDX_W'(w);
                end
                if (!seen || e.rank < best)
                begin
                    seen   = 1'b1;
                    best   = e.rank;
                    victim = WAY_IDX_W'(w);
                end
            end
        end

        row_new = row_cur;
        if (hit)
        begin
            if (policy == POL_LRU)
            begin
                do_promote = 1'b1;
                chosen     = hit_way;
                top        = RANK_W'(nvalid - 1'b1);
            end
        end
        else if (has_free)
        begin
            target               = base | free_way;
            row_new[target].tag   = tag;
            row_new[target].valid = 1'b1;
            row_new[target].rank  = RANK_W'(nvalid);
        end
        else if (policy == POL_FIFO || policy == POL_LRU)
        begin
            do_promote          = 1'b1;
            chosen              = victim;
            top                 = RANK_W'(ways_mask);
            target              = base | victim;
            row_new[target].tag = tag;
        end
        else
        begin
            lfsr_adv            = 1'b1;
            target              = base | (pick & ways_mask);
            row_new[target].tag = tag;
        end

        // Ways ranked above the chosen one move down; the chosen one goes on top.
        if (do_promote)
        begin
            r_chosen = row_cur[base | chosen].rank;
            for (int w = 0; w < WAY_MAX; w++)
            begin
                col = base | WAY_IDX_W'(w);
                if ((WAY_IDX_W'(w) & ~ways_mask) == '0 && WAY_IDX_W'(w) != chosen
                    && row_cur[col].valid && row_cur[col].rank > r_chosen)
                begin
                    row_new[col].rank = row_cur[col].rank - 1'b1;
                end
            end
            row_new[base | chosen].rank = top;
        end
    end

endmodule

FILE: rtl/core/sacl_datapath.sv
// Datapath of the lookup unit: configuration, address split, tag memory,
// row touch flags, counters, LFSR and result register. Depends on sacl_pkg.
module sacl_datapath import sacl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ADDR_W-1:0]     address,
    input  sacl_cmd_t             cmd,
    output sacl_status_t          status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  hit,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total
);

    logic [1:0]             policy_reg;
    logic [1:0]             ways_log2_reg;
    logic [3:0]             blocks_log2_reg;
    logic [2:0]             block_bytes_log2_reg;

    logic [3:0]             bl_eff;
    logic [2:0]             ob_eff;
    logic [3:0]             ib;
    logic [4:0]             tag_shift;
    logic [ADDR_W-1:0]      sh_set;
    logic [ADDR_W-1:0]      sh_tag;
    logic [ENTRY_IDX_W-1:0] set_mask;
    logic [ENTRY_IDX_W-1:0] set_idx;
    logic [ENTRY_IDX_W-1:0] entry;
    logic [ROW_IDX_W-1:0]   row_idx;

    row_t                   mem [ROWS];
    row_t                   mem_q_reg;
    logic [ROWS-1:0]        row_init_reg;
    logic                   rv_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [ROW_IDX_W-1:0]   row_reg;
    logic [WAY_IDX_W-1:0]   base_reg;
    logic [1:0]             wl_reg;
    logic [1:0]             pol_reg;

    row_t                   row_cur;
    row_t                   row_new;
    logic                   hit_now;
    logic                   lfsr_adv;
    logic [LFSR_W-1:0]      lfsr_reg;
    logic [LFSR_W-1:0]      lfsr_step;
    logic [CNT_W-1:0]       hit_count_reg;
    logic [CNT_W-1:0]       miss_count_reg;
    logic [CNT_W-1:0]       hit_count_next;
    logic [CNT_W-1:0]       miss_count_next;

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [CNT_W-1:0]       out_hit_total_reg;
    logic [CNT_W-1:0]       out_miss_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg           <= POLICY_RESET;
            ways_log2_reg        <= WAYS_LOG2_RESET;
            blocks_log2_reg      <= BLOCKS_LOG2_RESET;
            block_bytes_log2_reg <= OFFSET_LOG2_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_POLICY:           policy_reg           <= cfg_data[1:0];
                CFG_WAYS_LOG2:        ways_log2_reg        <= cfg_data[1:0];
                CFG_BLOCKS_LOG2:      blocks_log2_reg      <= cfg_data[3:0];
                CFG_BLOCK_BYTES_LOG2: block_bytes_log2_reg <= cfg_data[2:0];
                default:              ;
            endcase
        end
    end

    // Address split under the clamped geometry.
    always_comb
    begin
        priority if (blocks_log2_reg < BLOCKS_LOG2_MIN)
            bl_eff = BLOCKS_LOG2_MIN;
        else if (blocks_log2_reg > BLOCKS_LOG2_MAX)
            bl_eff = BLOCKS_LOG2_MAX;
        else
            bl_eff = blocks_log2_reg;
        ob_eff    = (block_bytes_log2_reg > OFFSET_LOG2_MIN) ? OFFSET_LOG2_MAX : OFFSET_LOG2_MIN;
        ib        = bl_eff - {2'b00, ways_log2_reg};
        set_mask  = ENTRY_IDX_W'((11'd1 << ib) - 11'd1);
        sh_set    = address >> ob_eff;
        set_idx   = sh_set[ENTRY_IDX_W-1:0] & set_mask;
        tag_shift = {2'b00, ob_eff} + {1'b0, ib};
        sh_tag    = address >> tag_shift;
        entry     = set_idx << ways_log2_reg;
        row_idx   = entry[ENTRY_IDX_W-1:WAY_IDX_W];
    end

    // Registered memory read on request acceptance, full-row write on commit.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem_q_reg <= mem[row_idx];
            tag_reg   <= sh_tag[TAG_W-1:0];
            row_reg   <= row_idx;
            base_reg  <= entry[WAY_IDX_W-1:0];
            wl_reg    <= ways_log2_reg;
            pol_reg   <= policy_reg;
        end
        if (cmd.commit)
        begin
            mem[row_reg] <= row_new;
        end
    end

    // A row never written reads as all ways invalid with rank zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg <= '0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rv_reg <= row_init_reg[row_idx];
            end
            if (cmd.commit)
            begin
                row_init_reg[row_reg] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAY_MAX; w++)
        begin
            row_cur[w].tag   = mem_q_reg[w].tag;
            row_cur[w].valid = rv_reg & mem_q_reg[w].valid;
            row_cur[w].rank  = rv_reg ? mem_q_reg[w].rank : '0;
        end
    end

    assign lfsr_step = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    sacl_row_update u_row_update (
        .row_cur  (row_cur),
        .tag      (tag_reg),
        .base     (base_reg),
        .wl       (wl_reg),
        .policy   (pol_reg),
        .pick     (lfsr_step[WAY_IDX_W-1:0]),
        .row_new  (row_new),
        .hit      (hit_now),
        .lfsr_adv (lfsr_adv)
    );

    assign hit_count_next  = hit_count_reg + (hit_now ? CNT_W'(1) : CNT_W'(0));
    assign miss_count_next = miss_count_reg + (hit_now ? CNT_W'(0) : CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            lfsr_reg       <= LFSR_SEED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                hit_count_reg  <= hit_count_next;
                miss_count_reg <= miss_count_next;
                out_valid_reg  <= 1'b1;
                if (lfsr_adv)
                begin
                    lfsr_reg <= lfsr_step;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg        <= hit_now;
            out_hit_total_reg  <= hit_count_next;
            out_miss_total_reg <= miss_count_next;
        end
    end

    assign status.slot_free = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign hit              = out_hit_reg;
    assign hit_total        = out_hit_total_reg;
    assign miss_total       = out_miss_total_reg;

endmodule

FILE: rtl/core/sacl_ctrl.sv
// Controller of the lookup unit: accepts a request, then commits the
// lookup once the result register is free. Depends on sacl_pkg.
module sacl_ctrl import sacl_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sacl_status_t status,
    output sacl_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    always_comb
    begin
        cmd.load   = in_valid && in_ready_reg;
        cmd.commit = (state_reg == ST_LOOKUP) && status.slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg    <= ST_LOOKUP;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_LOOKUP:
                begin
                    if (cmd.commit)
                    begin
                        state_reg    <= ST_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready = in_ready_reg;

endmodule
